>>> design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants, register indexes and types for the point projection.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0    = 3'd0,
    REG_ROT_ROW1    = 3'd1,
    REG_ROT_ROW2    = 3'd2,
    REG_TRANS_X     = 3'd3,
    REG_TRANS_Y     = 3'd4,
    REG_TRANS_Z     = 3'd5,
    REG_FOCAL_PAIR  = 3'd6,
    REG_CENTER_PAIR = 3'd7
  } cfg_reg_t;

  localparam logic [47:0] ROT_ROW0_RST    = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_ROW1_RST    = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW2_RST    = 48'h4000_0000_0000;
  localparam logic [47:0] FOCAL_PAIR_RST  = 48'h0001_0000_0100;

endpackage

>>> design/ppp_if.sv
// ----------------------------------------------------------------------------
// ppp_if
// Channel interfaces: world points in, pixel results out, register writes.
// ----------------------------------------------------------------------------
interface ppp_point_if #(parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_pixel_if #(parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pixel_u;
  logic signed [COORD_WIDTH-1:0] pixel_v;
  logic                          zero_depth;
  logic                          clipped;
  modport source (output valid, pixel_u, pixel_v, zero_depth, clipped, input ready);
  modport sink   (input valid, pixel_u, pixel_v, zero_depth, clipped, output ready);
endinterface

interface ppp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppp_pkg::CFG_IDX_W-1:0]   index;
  logic [ppp_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ppp_div.sv
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider: one quotient bit per stage, stall by enable.
// ----------------------------------------------------------------------------
module ppp_div #(
  parameter int NW = 96,   // dividend magnitude width
  parameter int DW = 50,   // divisor magnitude width
  parameter int TW = 3     // side-band width
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  logic          vld [1:NW];
  logic [NW-1:0] num [1:NW];
  logic [DW-1:0] den [1:NW];
  logic [DW:0]   rem [1:NW];
  logic [TW-1:0] tag [1:NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   rem_in;
    logic [TW-1:0] tag_in;
    logic [DW+1:0] trial;
    logic [DW:0]   rem_next;
    logic [NW-1:0] num_next;
    if (s == 0) begin : g_head
      assign vld_in = in_valid;
      assign num_in = in_num;
      assign den_in = in_den;
      assign rem_in = '0;
      assign tag_in = in_tag;
    end else begin : g_body
      assign vld_in = vld[s];
      assign num_in = num[s];
      assign den_in = den[s];
      assign rem_in = rem[s];
      assign tag_in = tag[s];
    end
    always_comb begin
      trial    = {rem_in, num_in[NW-1]};
      num_next = {num_in[NW-2:0], 1'b0};
      rem_next = trial[DW:0];
      if (trial >= {2'b0, den_in}) begin
        rem_next    = (DW+1)'(trial - {2'b0, den_in});
        num_next[0] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num[s+1] <= num_next;
        den[s+1] <= den_in;
        rem[s+1] <= rem_next;
        tag[s+1] <= tag_in;
      end
    end
  end

  assign out_valid = vld[NW];
  assign out_quo   = num[NW];
  assign out_tag   = tag[NW];

endmodule

>>> design/pinhole_point_projection.sv
// ----------------------------------------------------------------------------
// pinhole_point_projection
// Rotates and translates a world point, then projects it to pixel u,v.
// ----------------------------------------------------------------------------
// One point is taken per cycle while the output is not stalled. Each point
// passes the rotation, camera, focal product and numerator stages, the dividers
// for u and v side by side (bit per stage; NUM_W is the dividend width,
// COORD_WIDTH + 52) and the output register. The whole pipe advances together
// and holds for as long as a finished item waits at the output, so input and
// output stall together. Depth zero gives zero pixels with zero_depth set;
// quotients beyond the signed coordinate range saturate with clipped set.
module pinhole_point_projection #(
  parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  ppp_point_if.sink   points,
  ppp_pixel_if.source pixels,
  ppp_cfg_if.sink     cfg
);

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = CW + 16;        // rotation product
  localparam int CAMW  = CW + 18;        // camera coordinate
  localparam int NPW   = CAMW + 26;      // f*a + c*z
  localparam int NUM_W = NPW + 8;        // scaled numerator magnitude
  localparam int LAT_W = 1;

  // configuration
  logic [47:0]        rot_row [3];
  logic signed [31:0] trans [3];
  logic [47:0]        focal_pair, center_pair;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0]  <= ppp_pkg::ROT_ROW0_RST;
      rot_row[1]  <= ppp_pkg::ROT_ROW1_RST;
      rot_row[2]  <= ppp_pkg::ROT_ROW2_RST;
      trans[0]    <= '0;
      trans[1]    <= '0;
      trans[2]    <= '0;
      focal_pair  <= ppp_pkg::FOCAL_PAIR_RST;
      center_pair <= '0;
    end else if (cfg.valid) begin
      unique case (ppp_pkg::cfg_reg_t'(cfg.index))
        ppp_pkg::REG_ROT_ROW0:    rot_row[0]  <= cfg.data;
        ppp_pkg::REG_ROT_ROW1:    rot_row[1]  <= cfg.data;
        ppp_pkg::REG_ROT_ROW2:    rot_row[2]  <= cfg.data;
        ppp_pkg::REG_TRANS_X:     trans[0]    <= cfg.data[31:0];
        ppp_pkg::REG_TRANS_Y:     trans[1]    <= cfg.data[31:0];
        ppp_pkg::REG_TRANS_Z:     trans[2]    <= cfg.data[31:0];
        ppp_pkg::REG_FOCAL_PAIR:  focal_pair  <= cfg.data;
        ppp_pkg::REG_CENTER_PAIR: center_pair <= cfg.data;
        default: ;
      endcase
    end
  end

  // global pipe enable: output register empty or being drained
  logic en;
  logic out_vld;
  assign en           = !out_vld || pixels.ready;
  assign points.ready = en;

  // stage 1: nine products
  logic              s1_vld;
  logic signed [PW-1:0] s1_prod [3][3];
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= points.valid;
  end
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [CW-1:0] pc;
      assign pc = (c == 0) ? points.point_x : (c == 1) ? points.point_y : points.point_z;
      always_ff @(posedge clk) begin
        if (en) s1_prod[r][c] <= PW'($signed(rot_row[r][16*c +: 16]) * pc);
      end
    end
  end

  // stage 2: camera coordinates; sum of floors plus carry of the fractions
  // equals floor of the exact sum
  logic                   s2_vld;
  logic signed [CAMW-1:0] s2_cam [3];
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
  end
  for (genvar r = 0; r < 3; r++) begin : g_cam
    logic signed [PW+1:0] sum;
    assign sum = PW'(0) + s1_prod[r][0] + s1_prod[r][1] + s1_prod[r][2];
    always_ff @(posedge clk) begin
      if (en) s2_cam[r] <= CAMW'(sum >>> 14) + CAMW'(trans[r]);
    end
  end

  // stage 3: f*a and c*z products
  logic                  s3_vld;
  logic signed [NPW-1:0] s3_fa [2];
  logic signed [NPW-1:0] s3_cz [2];
  logic signed [CAMW-1:0] s3_z;
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (en) s3_vld <= s2_vld;
  end
  for (genvar k = 0; k < 2; k++) begin : g_fp
    always_ff @(posedge clk) begin
      if (en) begin
        s3_fa[k] <= NPW'(s2_cam[k] * $signed({1'b0, focal_pair[24*k +: 24]}));
        s3_cz[k] <= NPW'(s2_cam[2] * $signed({1'b0, center_pair[24*k +: 24]}));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) s3_z <= s2_cam[2];
  end

  // stage 4: numerator sum, signs and magnitudes
  logic                  s4_vld;
  logic [NUM_W-1:0]      s4_num [2];
  logic [1:0]            s4_neg;
  logic [CAMW-1:0]       s4_den;
  logic                  s4_zero;
  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (en) s4_vld <= s3_vld;
  end
  for (genvar k = 0; k < 2; k++) begin : g_num
    logic signed [NPW:0] n;
    assign n = (NPW+1)'(s3_fa[k]) + (NPW+1)'(s3_cz[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        s4_num[k] <= NUM_W'(n[NPW] ? -n : n) << 8;
        s4_neg[k] <= n[NPW] ^ s3_z[CAMW-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_den  <= s3_z[CAMW-1] ? CAMW'(-s3_z) : CAMW'(s3_z);
      s4_zero <= (s3_z == '0);
    end
  end

  // dividers
  logic             d_vld [2];
  logic [NUM_W-1:0] d_quo [2];
  logic [2:0]       d_tag [2];
  for (genvar k = 0; k < 2; k++) begin : g_div
    ppp_div #(.NW(NUM_W), .DW(CAMW), .TW(3)) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (s4_vld),
      .in_num    (s4_num[k]),
      .in_den    (s4_den),
      .in_tag    ({s4_zero, s4_neg}),
      .out_valid (d_vld[k]),
      .out_quo   (d_quo[k]),
      .out_tag   (d_tag[k])
    );
  end

  // saturation and output register
  logic [CW-1:0] pix [2];
  logic [1:0]    clip;
  for (genvar k = 0; k < 2; k++) begin : g_sat
    logic [CW-1:0]    lim;
    logic [NUM_W-1:0] q;
    always_comb begin
      lim = d_tag[k][k] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      q   = d_quo[k];
      clip[k] = (q > NUM_W'(lim));
      if (clip[k]) q = NUM_W'(lim);
      pix[k] = d_tag[k][k] ? CW'(-q) : CW'(q);
    end
  end

  logic zero_out;
  assign zero_out = d_tag[0][2];

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= d_vld[0] && LAT_W'(d_vld[1]) == 1'b1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pixels.pixel_u    <= zero_out ? '0 : pix[0];
      pixels.pixel_v    <= zero_out ? '0 : pix[1];
      pixels.zero_depth <= zero_out;
      pixels.clipped    <= !zero_out && (clip != 2'b00);
    end
  end
  assign pixels.valid = out_vld;

endmodule
